// ===== rtl/core/ecal_pkg.sv =====
package ecal_pkg;

    // Width of the shared add/subtract unit and of the signed day count.
    localparam int ALU_W = 20;
    localparam int REM_W = 17;
    // Operand width of the shared multiplier; the product is twice as wide.
    localparam int MUL_W = 26;

    typedef logic signed [ALU_W-1:0] alu_word_t;
    typedef logic [MUL_W-1:0]        mul_word_t;
    typedef logic [2*MUL_W-1:0]      mul_prod_t;

    typedef struct packed {
        alu_word_t a;
        alu_word_t b;
        logic      sub;
        mul_word_t ma;
        mul_word_t mb;
    } alu_req_t;

    typedef struct packed {
        alu_word_t sum;
        logic      neg;
        mul_prod_t prod;
    } alu_rsp_t;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [7:0] years_since_1900;
        logic [2:0] weekday;
        logic [8:0] day_of_year;
    } cal_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY_Q,
        ST_DAY_R,
        ST_SOD_FIX,
        ST_SOD_WRAP,
        ST_DAY_FIX,
        ST_HOUR,
        ST_HOUR_R,
        ST_MIN,
        ST_MIN_R,
        ST_YEAR_FWD,
        ST_YEAR_BWD,
        ST_MONTH,
        ST_DONE
    } state_t;

    // A day is 675 * 2^7 seconds. The day count is (u >> 7) times 2^35 / 675
    // rounded up, shifted right by 35; this is exact for every u below 2^32.
    localparam mul_word_t DAY_RECIP    = MUL_W'(50903317);
    localparam mul_word_t DAY_DIV_HI   = MUL_W'(675);
    localparam int        DAY_Q_SHIFT  = 35;
    // An hour is 225 * 2^4 seconds; 2^21 / 225 rounded up is exact below 86400.
    localparam mul_word_t HOUR_RECIP   = MUL_W'(9321);
    localparam int        HOUR_Q_SHIFT = 21;
    // A minute is 15 * 2^2 seconds; 2^14 / 15 rounded up is exact below 3600.
    localparam mul_word_t MIN_RECIP    = MUL_W'(1093);
    localparam int        MIN_Q_SHIFT  = 14;

    localparam mul_word_t SECS_PER_HOUR = MUL_W'(3600);
    localparam mul_word_t SECS_PER_MIN  = MUL_W'(60);
    // 2^31 = 24855 days plus 11648 seconds; 86400 - 11648 = 74752.
    localparam alu_word_t BIAS_SOD      = ALU_W'(11648);
    localparam alu_word_t BIAS_SOD_WRAP = ALU_W'(74752);
    localparam alu_word_t BIAS_DAYS     = ALU_W'(24855);

    localparam logic [7:0] EPOCH_YS      = 8'd70;
    localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;
    localparam logic [3:0] MON_FEB       = 4'd1;
    localparam logic [3:0] MON_DEC       = 4'd11;

    // Gregorian rule for 1900 + ys; exact for the whole 8-bit range.
    function automatic logic is_leap(input logic [7:0] ys);
        return (ys[1:0] == 2'b00) && (ys != 8'd0) && (ys != 8'd200);
    endfunction

    function automatic alu_word_t year_len(input logic [7:0] ys);
        return is_leap(ys) ? ALU_W'(366) : ALU_W'(365);
    endfunction

    function automatic logic [4:0] month_len(input logic [7:0] ys, input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            MON_FEB:                 len = is_leap(ys) ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] add_mod7(input logic [2:0] w, input logic [2:0] k);
        logic [3:0] s;
        s = {1'b0, w} + {1'b0, k};
        return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
    endfunction

    // Valid for x below 42.
    function automatic logic [2:0] mod7_small(input logic [5:0] x);
        logic [5:0] v;
        v = x;
        if (v >= 6'd28) v = v - 6'd28;
        if (v >= 6'd14) v = v - 6'd14;
        if (v >= 6'd7)  v = v - 6'd7;
        return v[2:0];
    endfunction

endpackage

// ===== rtl/core/epoch_to_calendar_time_unit.sv =====
// Epoch seconds to broken-down UTC calendar time (proleptic Gregorian).
// Input channel: s_valid/s_ready with s_epoch_seconds, a signed 32-bit count of
// seconds since 1970-01-01 00:00:00 UTC. Every 32-bit value is a legal time.
// Result channel: m_valid/m_ready with second, minute, hour, day of month,
// month, years since 1900, weekday and day of year, one result per transfer in.
// Negative times use floor division, so they land on earlier calendar days.
// From input transfer to m_valid all work runs on one shared adder and
// multiplier: days are split from seconds by a reciprocal multiplication
// (ST_DAY_Q, ST_DAY_R), the bias is corrected (ST_SOD_FIX, ST_SOD_WRAP when
// needed, ST_DAY_FIX), hours and minutes are split out (ST_HOUR, ST_HOUR_R,
// ST_MIN, ST_MIN_R), the years from 1970 and then the months are walked
// (ST_YEAR_FWD or ST_YEAR_BWD, ST_MONTH), and ST_DONE hands the result on.
// The unit works on one item at a time; s_ready is high only while it is idle.
// A finished result moves into the output register, so the next item can be
// taken while the receiver still holds off the previous result. If the output
// register is still full, the finished result waits in the sequencer.
// Synchronous active-low reset returns the sequencer to idle and empties the
// output register; no item in progress survives it.
module epoch_to_calendar_time_unit
    import ecal_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_epoch_seconds,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_second,
    output logic [5:0]         m_minute,
    output logic [4:0]         m_hour,
    output logic [4:0]         m_day_of_month,
    output logic [3:0]         m_month,
    output logic [7:0]         m_years_since_1900,
    output logic [2:0]         m_weekday,
    output logic [8:0]         m_day_of_year
);

    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    cal_result_t result;
    cal_result_t out_reg, out_next;
    logic        m_valid_reg, m_valid_next;
    logic        seq_idle;
    logic        res_valid;
    logic        res_take;
    logic        start;

    ecal_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    ecal_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (start),
        .epoch_seconds (s_epoch_seconds),
        .res_take      (res_take),
        .idle          (seq_idle),
        .res_valid     (res_valid),
        .result        (result),
        .alu_req       (alu_req),
        .alu_rsp       (alu_rsp)
    );

    assign s_ready = seq_idle;
    assign start   = s_valid && seq_idle;

    // A result leaves the sequencer when the output register is empty or
    // is being emptied by a transfer in this same cycle.
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (res_take) begin
            out_next     = result;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_second           = out_reg.second;
    assign m_minute           = out_reg.minute;
    assign m_hour             = out_reg.hour;
    assign m_day_of_month     = out_reg.day_of_month;
    assign m_month            = out_reg.month;
    assign m_years_since_1900 = out_reg.years_since_1900;
    assign m_weekday          = out_reg.weekday;
    assign m_day_of_year      = out_reg.day_of_year;

endmodule

// ===== rtl/core/ecal_alu.sv =====
module ecal_alu
    import ecal_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    alu_word_t sum;

    // Every step of the conversion goes through this one adder and this one
    // multiplier.
    assign sum      = req.sub ? (req.a - req.b) : (req.a + req.b);
    assign rsp.sum  = sum;
    assign rsp.neg  = sum[ALU_W-1];
    assign rsp.prod = mul_prod_t'(req.ma) * mul_prod_t'(req.mb);

endmodule

// ===== rtl/core/ecal_seq.sv =====
module ecal_seq
    import ecal_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] epoch_seconds,
    input  logic               res_take,
    output logic               idle,
    output logic               res_valid,
    output cal_result_t        result,
    output alu_req_t           alu_req,
    input  alu_rsp_t           alu_rsp
);

    state_t           state_reg, state_next;
    logic [31:0]      num_reg, num_next;
    logic [15:0]      quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic             wrap_reg, wrap_next;
    alu_word_t        day_reg, day_next;
    logic [4:0]       hour_reg, hour_next;
    logic [5:0]       min_reg, min_next;
    logic [7:0]       ys_reg, ys_next;
    logic [3:0]       mon_reg, mon_next;
    logic [2:0]       wd_reg, wd_next;
    logic [8:0]       yday_reg, yday_next;

    logic [7:0]       ys_prev;
    logic [4:0]       mlen;

    assign ys_prev   = ys_reg - 8'd1;
    assign mlen      = month_len(ys_reg, mon_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        wrap_reg <= wrap_next;
        day_reg  <= day_next;
        hour_reg <= hour_next;
        min_reg  <= min_next;
        ys_reg   <= ys_next;
        mon_reg  <= mon_next;
        wd_reg   <= wd_next;
        yday_reg <= yday_next;
    end

    always_comb begin
        state_next = state_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        wrap_next  = wrap_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        ys_next    = ys_reg;
        mon_next   = mon_reg;
        wd_next    = wd_reg;
        yday_next  = yday_reg;
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b1;
        alu_req.ma  = '0;
        alu_req.mb  = '0;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    // Flipping the sign bit adds 2^31, so the divider sees an unsigned value.
                    num_next   = {~epoch_seconds[31], epoch_seconds[30:0]};
                    state_next = ST_DAY_Q;
                end
            end
            ST_DAY_Q: begin
                alu_req.ma = MUL_W'(num_reg[31:7]);
                alu_req.mb = DAY_RECIP;
                quo_next   = alu_rsp.prod[DAY_Q_SHIFT+15:DAY_Q_SHIFT];
                state_next = ST_DAY_R;
            end
            ST_DAY_R: begin
                // The remainder of (u >> 7) by 675 is below 2^10, so the low
                // adder bits carry it exactly.
                alu_req.ma = MUL_W'(quo_reg);
                alu_req.mb = DAY_DIV_HI;
                alu_req.a  = num_reg[ALU_W+6:7];
                alu_req.b  = alu_rsp.prod[ALU_W-1:0];
                rem_next   = {alu_rsp.sum[9:0], num_reg[6:0]};
                state_next = ST_SOD_FIX;
            end
            ST_SOD_FIX: begin
                alu_req.a = ALU_W'(rem_reg);
                alu_req.b = BIAS_SOD;
                wrap_next = alu_rsp.neg;
                if (alu_rsp.neg) begin
                    state_next = ST_SOD_WRAP;
                end else begin
                    rem_next   = alu_rsp.sum[REM_W-1:0];
                    state_next = ST_DAY_FIX;
                end
            end
            ST_SOD_WRAP: begin
                alu_req.a   = ALU_W'(rem_reg);
                alu_req.b   = BIAS_SOD_WRAP;
                alu_req.sub = 1'b0;
                rem_next    = alu_rsp.sum[REM_W-1:0];
                state_next  = ST_DAY_FIX;
            end
            ST_DAY_FIX: begin
                alu_req.a  = ALU_W'(quo_reg);
                alu_req.b  = wrap_reg ? (BIAS_DAYS + ALU_W'(1)) : BIAS_DAYS;
                day_next   = alu_rsp.sum;
                ys_next    = EPOCH_YS;
                wd_next    = EPOCH_WEEKDAY;
                state_next = ST_HOUR;
            end
            ST_HOUR: begin
                alu_req.ma = MUL_W'(rem_reg[16:4]);
                alu_req.mb = HOUR_RECIP;
                hour_next  = alu_rsp.prod[HOUR_Q_SHIFT+4:HOUR_Q_SHIFT];
                state_next = ST_HOUR_R;
            end
            ST_HOUR_R: begin
                alu_req.ma = MUL_W'(hour_reg);
                alu_req.mb = SECS_PER_HOUR;
                alu_req.a  = ALU_W'(rem_reg);
                alu_req.b  = alu_rsp.prod[ALU_W-1:0];
                rem_next   = alu_rsp.sum[REM_W-1:0];
                state_next = ST_MIN;
            end
            ST_MIN: begin
                alu_req.ma = MUL_W'(rem_reg[11:2]);
                alu_req.mb = MIN_RECIP;
                min_next   = alu_rsp.prod[MIN_Q_SHIFT+5:MIN_Q_SHIFT];
                state_next = ST_MIN_R;
            end
            ST_MIN_R: begin
                alu_req.ma = MUL_W'(min_reg);
                alu_req.mb = SECS_PER_MIN;
                alu_req.a  = ALU_W'(rem_reg);
                alu_req.b  = alu_rsp.prod[ALU_W-1:0];
                rem_next   = alu_rsp.sum[REM_W-1:0];
                state_next = day_reg[ALU_W-1] ? ST_YEAR_BWD : ST_YEAR_FWD;
            end
            ST_YEAR_FWD: begin
                alu_req.a = day_reg;
                alu_req.b = year_len(ys_reg);
                if (alu_rsp.neg) begin
                    yday_next  = day_reg[8:0];
                    mon_next   = '0;
                    state_next = ST_MONTH;
                end else begin
                    day_next = alu_rsp.sum;
                    ys_next  = ys_reg + 8'd1;
                    wd_next  = add_mod7(wd_reg, is_leap(ys_reg) ? 3'd2 : 3'd1);
                end
            end
            ST_YEAR_BWD: begin
                alu_req.a   = day_reg;
                alu_req.b   = year_len(ys_prev);
                alu_req.sub = 1'b0;
                day_next    = alu_rsp.sum;
                ys_next     = ys_prev;
                wd_next     = add_mod7(wd_reg, is_leap(ys_prev) ? 3'd5 : 3'd6);
                if (!alu_rsp.neg) begin
                    yday_next  = alu_rsp.sum[8:0];
                    mon_next   = '0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                alu_req.a = day_reg;
                alu_req.b = ALU_W'(mlen);
                if (mon_reg == MON_DEC || alu_rsp.neg) begin
                    state_next = ST_DONE;
                end else begin
                    day_next = alu_rsp.sum;
                    mon_next = mon_reg + 4'd1;
                    wd_next  = add_mod7(wd_reg, 3'(mlen - 5'd28));
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    assign result.second           = rem_reg[5:0];
    assign result.minute           = min_reg;
    assign result.hour             = hour_reg;
    assign result.day_of_month     = day_reg[4:0] + 5'd1;
    assign result.month            = mon_reg;
    assign result.years_since_1900 = ys_reg;
    assign result.weekday          = mod7_small({3'b000, wd_reg} + {1'b0, day_reg[4:0]});
    assign result.day_of_year      = yday_reg;

endmodule

// ===== sim/calendar_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the calendar unit. Every input transfer queues the
// calendar time that it should produce, and every result transfer is compared
// with the oldest queued entry.
module calendar_checker
    import ecal_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_epoch_seconds,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [5:0]         m_second,
    input  logic [5:0]         m_minute,
    input  logic [4:0]         m_hour,
    input  logic [4:0]         m_day_of_month,
    input  logic [3:0]         m_month,
    input  logic [7:0]         m_years_since_1900,
    input  logic [2:0]         m_weekday,
    input  logic [8:0]         m_day_of_year,
    output int                 fail_count,
    output int                 pending_count
);

    cal_result_t expected_times[$];

    initial fail_count = 0;
    assign pending_count = expected_times.size();

    function automatic bit is_leap_year(input int year);
        return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    endfunction

    function automatic int days_in_year(input int year);
        return is_leap_year(year) ? 366 : 365;
    endfunction

    function automatic int days_in_month(input int year, input int mon);
        int len;
        case (mon)
            3, 5, 8, 10: len = 30;
            MON_FEB:     len = is_leap_year(year) ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    // Floor division into days and second of day, then walk the years away
    // from 1970 and the months through the year found.
    function automatic cal_result_t predict_calendar_time(input logic signed [31:0] secs);
        longint      t;
        longint      days;
        longint      sod;
        longint      d;
        longint      wd;
        int          year;
        int          mon;
        cal_result_t r;
        t = secs;
        days = t / 86400;
        sod = t % 86400;
        if (sod < 0) begin
            sod += 86400;
            days -= 1;
        end
        d = days;
        year = 1970;
        if (d >= 0) begin
            while (d >= days_in_year(year)) begin
                d -= days_in_year(year);
                year++;
            end
        end else begin
            do begin
                year--;
                d += days_in_year(year);
            end while (d < 0);
        end
        r.day_of_year = 9'(d);
        mon = 0;
        while (mon < MON_DEC && d >= days_in_month(year, mon)) begin
            d -= days_in_month(year, mon);
            mon++;
        end
        wd = (days + 4) % 7;
        if (wd < 0) wd += 7;
        r.second = 6'(sod % 60);
        r.minute = 6'((sod / 60) % 60);
        r.hour = 5'(sod / 3600);
        r.day_of_month = 5'(d + 1);
        r.month = 4'(mon);
        r.years_since_1900 = 8'(year - 1900);
        r.weekday = 3'(wd);
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        cal_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_times.push_back(predict_calendar_time(s_epoch_seconds));
            if (m_valid && m_ready) begin
                if (expected_times.size() == 0) begin
                    $error("result transfer with no input waiting for it");
                    fail_count++;
                end else begin
                    want = expected_times.pop_front();
                    compare_field("second", want.second, m_second);
                    compare_field("minute", want.minute, m_minute);
                    compare_field("hour", want.hour, m_hour);
                    compare_field("day_of_month", want.day_of_month, m_day_of_month);
                    compare_field("month", want.month, m_month);
                    compare_field("years_since_1900", want.years_since_1900,
                                  m_years_since_1900);
                    compare_field("weekday", want.weekday, m_weekday);
                    compare_field("day_of_year", want.day_of_year, m_day_of_year);
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

// Top of the calendar unit testbench. This module only makes stimulus and
// gives the verdict; the checker beside the unit does all prediction and
// comparison and reports its failure count back here.
module tb_top;
    import ecal_pkg::*;

    localparam int  RANDOM_TIMES = 400;
    // The slowest correct run is 420 items, each with its work and a long gap
    // on each side. Allow many times that.
    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam int  DRAIN_CYCLES = 200;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_epoch_seconds = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [5:0]         m_second;
    logic [5:0]         m_minute;
    logic [4:0]         m_hour;
    logic [4:0]         m_day_of_month;
    logic [3:0]         m_month;
    logic [7:0]         m_years_since_1900;
    logic [2:0]         m_weekday;
    logic [8:0]         m_day_of_year;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    // While set, neither side inserts gaps, so back-to-back transfers occur.
    bit calm = 1'b0;
    int ready_hold = 0;

    epoch_to_calendar_time_unit i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_epoch_seconds    (s_epoch_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_second           (m_second),
        .m_minute           (m_minute),
        .m_hour             (m_hour),
        .m_day_of_month     (m_day_of_month),
        .m_month            (m_month),
        .m_years_since_1900 (m_years_since_1900),
        .m_weekday          (m_weekday),
        .m_day_of_year      (m_day_of_year)
    );

    calendar_checker i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_epoch_seconds    (s_epoch_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_second           (m_second),
        .m_minute           (m_minute),
        .m_hour             (m_hour),
        .m_day_of_month     (m_day_of_month),
        .m_month            (m_month),
        .m_years_since_1900 (m_years_since_1900),
        .m_weekday          (m_weekday),
        .m_day_of_year      (m_day_of_year),
        .fail_count         (fail_count),
        .pending_count      (pending_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Gap lengths: mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(12, 48);
    endfunction

    // The receiver alternates between runs with ready high and stalls. Each
    // branch makes at most one assignment to m_ready per clock edge.
    always @(posedge aclk) begin
        int stall;
        stall = 0;
        if (aresetn) begin
            if (ready_hold != 0) begin
                ready_hold <= ready_hold - 1;
            end else if (calm || !m_ready) begin
                m_ready <= 1'b1;
                ready_hold <= calm ? 0 : $urandom_range(0, 12);
            end else begin
                stall = pick_gap();
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    ready_hold <= stall - 1;
                end
            end
        end
    end

    // The cycle counter ends a run that hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Present one time and hold it until the unit takes the transfer. Valid
    // is only dropped when a gap follows, so a back-to-back transfer never
    // lowers and raises it at the same edge.
    task automatic send_time(input logic signed [31:0] secs);
        int gap;
        s_valid <= 1'b1;
        s_epoch_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Random times come in three flavors: any 32-bit pattern, which covers
    // every bit of the field; times within 100000 seconds of the epoch; and times a
    // second around midnight, where day, month and year boundaries sit.
    function automatic logic signed [31:0] random_time();
        longint day;
        logic signed [31:0] secs;
        case ($urandom_range(0, 3))
            0, 1: secs = $urandom;
            2:    secs = 32'($signed($urandom_range(0, 200000)) - 100000);
            default: begin
                day = longint'($urandom_range(0, 49709)) - 24855;
                secs = 32'(day * 86400 + longint'($urandom_range(0, 2)) - 1);
            end
        endcase
        return secs;
    endfunction

    initial begin
        logic signed [31:0] directed_times[$];

        // Directed times: the epoch and the seconds around it, both ends of
        // the 32-bit range, the last second of a day, leap days on both sides
        // of the epoch and in a century year, and several December 31sts
        // where the month search stops at December, some of them in leap years.
        directed_times = '{
            32'sd0, -32'sd1, 32'sd1, 32'sd86399, 32'sd86400, -32'sd86400,
            -32'sd86401, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
            32'hAAAA_AAAA, 32'sd951782400, 32'sd951868800, 32'sd94694399,
            32'sd978307199, 32'sd2145916799, -32'sd2145916801, -32'sd58060800,
            -32'sd63158401, 32'sd68169599
        };

        // Reset once, at the start of the run.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_times[i])
            send_time(directed_times[i]);

        for (int n = 0; n < RANDOM_TIMES; n++) begin
            // One stretch of the random part runs with no idling at all.
            calm = (n >= 150) && (n < 210);
            send_time(random_time());
        end
        calm = 1'b0;
        s_valid <= 1'b0;
        // Let the checker record the last input transfer before counting.
        @(posedge aclk);

        // Wait for every expected result, then give the unit time to show
        // any result it should not produce.
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
